// ===== hw/rtl/tccw_pkg.sv =====
package tccw_pkg;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_PUT,
    ST_RDCAP,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SWEEP,
    OP_PUT,
    OP_RDCAP,
    OP_SCR_RD,
    OP_SCR_WR,
    OP_FILL,
    OP_RESULT
  } op_t;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } ctl_t;

  typedef struct packed {
    logic sweep_last;
    logic scroll_req;
    logic tab_more;
    logic copy_last;
    logic fill_last;
    logic no_copy;
    logic area_zero;
    logic res_busy;
  } sts_t;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int unsigned CFG_DW = 32;
  localparam int unsigned CFG_AW = 3;

endpackage

// ===== hw/rtl/text_console_char_writer.sv =====
// Text console cell store. Each input item is a command (in_tuser): put one byte at the
// cursor, clear the screen, read one cell, or no-op; each gives exactly one result item
// with the cell byte, the cursor after the command and the range of rows it changed.
// A byte goes through a put step (a tab repeats it, storing a space each time, until the
// column is a multiple of four or the line wraps), a read through a capture step and a no-op
// straight to the result step. A scroll copies the active area through the one grid RAM port
// pair, reading each cell and writing it one row up, then fills the last row with spaces.
// Clear and the pass after reset write every one of the MAX_ROWS*MAX_COLS cells, one per
// cycle (32768 cells at default size); no item is accepted meanwhile, register writes are.
// The next item is taken the cycle after the result is loaded. The finished result sits in
// an output register, so the next item is taken while it waits. active_cols at 0x0,
// active_rows at 0x4; values above the maximum saturate in use, wider bits are dropped.
module text_console_char_writer #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,  // char_in[7:0], read_row[14:8], read_col[22:15]
  input  logic [1:0]                    in_tuser,  // cmd[1:0]
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // cell_data[7:0], cursor_col_out[15:8], cursor_row_out[22:16],
  // dirty_first[29:23], dirty_last[36:30]
  output logic [39:0]                   out_tdata,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tccw_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tccw_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tccw_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import tccw_pkg::*;

  // config registers
  logic [8:0] cols_r;
  logic [7:0] rows_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 9'd80;
      rows_r <= 8'd25;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) rows_r <= cfg_pwdata[7:0];
      else              cols_r <= cfg_pwdata[8:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? CFG_DW'(rows_r) : CFG_DW'(cols_r);

  // working area, clipped to the grid
  logic [8:0] cols;
  logic [7:0] rows;
  assign cols = (cols_r > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cols_r;
  assign rows = ({1'b0, rows_r} > 9'(MAX_ROWS)) ? 8'(MAX_ROWS) : rows_r;

  ctl_t ctl;
  sts_t sts;
  cmd_t in_cmd;
  assign in_cmd = cmd_t'(in_tuser);

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_cmd),
    .sts       (sts),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  tccw_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .cols       (cols),
    .rows       (rows),
    .in_cmd     (in_cmd),
    .in_char    (in_tdata[7:0]),
    .in_row     (in_tdata[14:8]),
    .in_col     (in_tdata[22:15]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // dirty range is never inverted
  a_dirty_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:23] <= out_tdata[36:30]))
    else $error("dirty range inverted");

  // an accepted item is never followed by another accept in the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken back to back");

  // a fresh result only follows the controller's result step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(ctl.op == OP_RESULT))
    else $error("result without result step");

endmodule

// ===== hw/rtl/tccw_ctrl.sv =====
module tccw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  tccw_pkg::cmd_t  in_cmd,
  input  tccw_pkg::sts_t  sts,
  output logic            in_tready,
  output tccw_pkg::ctl_t  ctl
);
  import tccw_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    ctl.op     = OP_IDLE;
    ctl.accept = 1'b0;
    case (state_r)
      ST_INIT: begin
        ctl.op = OP_SWEEP;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.accept = 1'b1;
          case (in_cmd)
            CMD_PUT:   state_nxt = sts.area_zero ? ST_RESULT : ST_PUT;
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_READ:  state_nxt = ST_RDCAP;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR: begin
        ctl.op = OP_SWEEP;
        if (sts.sweep_last) state_nxt = ST_RESULT;
      end
      ST_PUT: begin
        ctl.op = OP_PUT;
        if (sts.scroll_req) state_nxt = sts.no_copy ? ST_FILL : ST_SCR_RD;
        else if (!sts.tab_more) state_nxt = ST_RESULT;
      end
      ST_RDCAP: begin
        ctl.op    = OP_RDCAP;
        state_nxt = ST_RESULT;
      end
      ST_SCR_RD: begin
        ctl.op    = OP_SCR_RD;
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ctl.op    = OP_SCR_WR;
        state_nxt = sts.copy_last ? ST_FILL : ST_SCR_RD;
      end
      ST_FILL: begin
        ctl.op = OP_FILL;
        if (sts.fill_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!sts.res_busy) begin
          ctl.op    = OP_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

endmodule

// ===== hw/rtl/tccw_dp.sv =====
module tccw_dp #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tccw_pkg::ctl_t  ctl,
  output tccw_pkg::sts_t  sts,
  input  logic [8:0]      cols,
  input  logic [7:0]      rows,
  input  tccw_pkg::cmd_t  in_cmd,
  input  logic [7:0]      in_char,
  input  logic [6:0]      in_row,
  input  logic [7:0]      in_col,
  input  logic            out_tready,
  output logic            out_tvalid,
  output logic [39:0]     out_tdata
);
  import tccw_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_q;

  logic [7:0]    cur_col_r;
  logic [6:0]    cur_line_r;
  logic [6:0]    old_line_r;
  logic          scrolled_r;
  logic [7:0]    ch_r;
  cmd_t          cmd_r;
  logic          rd_ok_r;
  logic [7:0]    data_r;
  logic [AW-1:0] sw_r;
  logic [7:0]    scr_row_r;
  logic [7:0]    scr_col_r;
  logic          out_valid_r;
  logic [39:0]   out_data_r;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [7:0] c);
    return AW'(AW'(r) * AW'(MAX_COLS) + AW'(c));
  endfunction

  // put step
  logic [8:0] col_inc;
  logic [7:0] line_inc;
  logic       lf_scroll, wrap, is_tab;
  logic [7:0] col_nx, store_val;
  logic [6:0] line_nx, last_row;
  logic       scroll_req, tab_more;
  logic       pw_en;
  logic [6:0] pw_row;
  logic [7:0] pw_col, pw_data;

  assign col_inc   = {1'b0, cur_col_r} + 9'd1;
  assign line_inc  = {1'b0, cur_line_r} + 8'd1;
  assign lf_scroll = line_inc >= rows;
  assign wrap      = col_inc >= cols;
  assign is_tab    = ch_r == CH_TAB;
  assign last_row  = 7'(rows - 8'd1);
  assign store_val = is_tab ? CH_SPACE :
                     ((ch_r < CH_SPACE) || (ch_r > CH_TILDE)) ? CH_QMARK : ch_r;

  always_comb begin
    col_nx     = cur_col_r;
    line_nx    = cur_line_r;
    scroll_req = 1'b0;
    tab_more   = 1'b0;
    pw_en      = 1'b0;
    pw_data    = CH_SPACE;
    if (ch_r == CH_LF) begin
      col_nx = '0;
      if (lf_scroll) begin
        scroll_req = 1'b1;
        line_nx    = last_row;
      end else begin
        line_nx = line_inc[6:0];
      end
    end else if (ch_r == CH_CR) begin
      col_nx = '0;
    end else if ((ch_r == CH_BS) || (ch_r == CH_DEL)) begin
      if (cur_col_r != 8'd0) begin
        col_nx = cur_col_r - 8'd1;
      end else if (cur_line_r != 7'd0) begin
        line_nx = cur_line_r - 7'd1;
        col_nx  = 8'(cols - 9'd1);
      end
      pw_en = 1'b1;
    end else begin
      pw_en   = 1'b1;
      pw_data = store_val;
      if (wrap) begin
        col_nx = '0;
        if (lf_scroll) begin
          scroll_req = 1'b1;
          line_nx    = last_row;
        end else begin
          line_nx = line_inc[6:0];
        end
      end else begin
        col_nx   = col_inc[7:0];
        tab_more = is_tab && (col_inc[1:0] != 2'd0);
      end
    end
  end

  // backspace blanks the new cursor cell, a store writes the old one
  always_comb begin
    if (pw_data == CH_SPACE && !(pw_en && !((ch_r == CH_BS) || (ch_r == CH_DEL)))) begin
      pw_row = line_nx;
      pw_col = col_nx;
    end else begin
      pw_row = cur_line_r;
      pw_col = cur_col_r;
    end
  end

  logic pw_ok;
  assign pw_ok = ({1'b0, pw_row} < 8'(MAX_ROWS)) && ({1'b0, pw_col} < 9'(MAX_COLS));

  // memory port muxing
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  always_comb begin
    we    = 1'b0;
    waddr = sw_r;
    wdata = CH_SPACE;
    case (ctl.op)
      OP_SWEEP: we = 1'b1;
      OP_PUT: begin
        we    = pw_en && pw_ok;
        waddr = cell_addr(pw_row, pw_col);
        wdata = pw_data;
      end
      OP_SCR_WR: begin
        we    = 1'b1;
        waddr = cell_addr(7'(scr_row_r - 8'd1), scr_col_r);
        wdata = rd_q;
      end
      OP_FILL: begin
        we    = 1'b1;
        waddr = cell_addr(last_row, scr_col_r);
      end
      default: we = 1'b0;
    endcase
  end

  assign raddr = (ctl.op == OP_SCR_RD) ? cell_addr(scr_row_r[6:0], scr_col_r)
                                       : cell_addr(in_row, in_col);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic rd_ok;
  assign rd_ok = ({1'b0, in_row} < 8'(MAX_ROWS)) && ({1'b0, in_col} < 9'(MAX_COLS));

  // result fields
  logic [6:0] first, last;
  always_comb begin
    first = '0;
    last  = '0;
    case (cmd_r)
      CMD_PUT: begin
        if (sts.area_zero) begin
          first = old_line_r;
          last  = old_line_r;
        end else if (scrolled_r) begin
          last = last_row;
        end else begin
          first = (cur_line_r < old_line_r) ? cur_line_r : old_line_r;
          last  = (cur_line_r > old_line_r) ? cur_line_r : old_line_r;
        end
      end
      CMD_CLEAR: last = (rows != 8'd0) ? last_row : 7'd0;
      default:   last = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_line_r  <= '0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sw_r <= (ctl.op == OP_SWEEP) ? sw_r + AW'(1) : '0;
      if (ctl.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.accept) begin
        ch_r       <= in_char;
        cmd_r      <= in_cmd;
        old_line_r <= cur_line_r;
        scrolled_r <= 1'b0;
        rd_ok_r    <= rd_ok;
        data_r     <= '0;
        if (in_cmd == CMD_CLEAR) begin
          cur_col_r  <= '0;
          cur_line_r <= '0;
        end
      end
      case (ctl.op)
        OP_PUT: begin
          cur_col_r  <= col_nx;
          cur_line_r <= line_nx;
          if (scroll_req) begin
            scrolled_r <= 1'b1;
            scr_row_r  <= 8'd1;
            scr_col_r  <= '0;
          end
        end
        OP_SCR_WR: begin
          if ({1'b0, scr_col_r} == cols - 9'd1) begin
            scr_col_r <= '0;
            scr_row_r <= scr_row_r + 8'd1;
          end else begin
            scr_col_r <= scr_col_r + 8'd1;
          end
        end
        OP_FILL:  scr_col_r <= scr_col_r + 8'd1;
        OP_RDCAP: data_r <= rd_ok_r ? rd_q : 8'd0;
        OP_RESULT: begin
          out_data_r  <= {3'd0, last, first, cur_line_r, cur_col_r, data_r};
        end
        default: ;
      endcase
    end
  end

  assign sts.sweep_last = sw_r == AW'(DEPTH - 1);
  assign sts.scroll_req = scroll_req;
  assign sts.tab_more   = tab_more;
  assign sts.copy_last  = (scr_row_r == rows - 8'd1) && ({1'b0, scr_col_r} == cols - 9'd1);
  assign sts.fill_last  = {1'b0, scr_col_r} == cols - 9'd1;
  assign sts.no_copy    = rows == 8'd1;
  assign sts.area_zero  = (cols == 9'd0) || (rows == 8'd0);
  assign sts.res_busy   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
